FILE: hdl/bucx_pkg.sv
// Shared constants for the buffered UART console with XON/XOFF handling.
// Operation, error and register codes, control characters and default depths.
// No dependencies.
package bucx_pkg;

   localparam int TX_DEPTH_DEFAULT = 64;
   localparam int RX_DEPTH_DEFAULT = 8;

   localparam int BYTE_W = 8;
   localparam int WAIT_W = 16;
   localparam int OP_W   = 2;
   localparam int ERR_W  = 2;
   localparam int CSR_AW = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   // sticky error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_TX_FULL = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TIMEOUT = 2'd2;
   localparam logic [ERR_W-1:0] ERR_RX_OVER = 2'd3;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_CRLF_ENABLE = 2'd0;
   localparam logic [CSR_AW-1:0] REG_FLOW_ENABLE = 2'd1;
   localparam logic [CSR_AW-1:0] REG_WAIT_LIMIT  = 2'd2;

   // control characters
   localparam logic [BYTE_W-1:0] CH_XON  = 8'h11;
   localparam logic [BYTE_W-1:0] CH_XOFF = 8'h13;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

   localparam logic [WAIT_W-1:0] WAIT_LIMIT_RESET = 16'hFFFF;

endpackage

FILE: hdl/bucx_store.sv
// Byte store with one write port and one registered read port.
// The read port follows a chosen entry; a same-cycle write to it is forwarded.
// Uses bucx_pkg.
module bucx_store
   import bucx_pkg::*;
#(
   parameter int DEPTH = TX_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward a write to the entry being followed
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/buffered_uart_console_xon_xoff.sv
// Console buffer between a host and a UART, with CR insertion and XON/XOFF.
// Depends on bucx_pkg and bucx_store.
//
// One request per cycle is taken: a request is registered, worked in one pass
// of short logic that makes one store access per store, and its result is
// registered, so the rate is one request per cycle while the result side keeps
// up. The next transmit byte and the next receive byte are kept in the registered
// read ports of the two stores, which follow the send and take indices. Registers
// are written through the csr_ port only while no request is in flight, by the
// user's rule; the block does not enforce it. Both stores power up undefined and
// need no clearing; the fill and take indices alone say what they hold.
module buffered_uart_console_xon_xoff
   import bucx_pkg::*;
#(
   parameter int TX_DEPTH = TX_DEPTH_DEFAULT,
   parameter int RX_DEPTH = RX_DEPTH_DEFAULT,
   parameter int TX_IW    = $clog2(TX_DEPTH + 1),
   parameter int RX_IW    = $clog2(RX_DEPTH + 1),
   parameter int RSP_W    = ((2 * BYTE_W + 2 + RX_IW + TX_IW + ERR_W + 1 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // request: tdata = write_byte[7:0], rx_valid, rx_byte[7:0], tx_ready; tuser = operation
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,
   input  logic [OP_W-1:0]   req_tuser,
   // response: tdata = tx_valid, tx_byte, read_valid, read_byte, rx_count,
   //           tx_pending, error_code, paused, zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [WAIT_W-1:0] csr_wdata
);

   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam logic [TX_IW-1:0] TX_FULL = TX_IW'(TX_DEPTH);
   localparam logic [RX_IW-1:0] RX_FULL = RX_IW'(RX_DEPTH);
   localparam int PAY_W = 2 * BYTE_W + 2 + RX_IW + TX_IW + ERR_W + 1;

   // configuration
   logic              crlf_enable_ff;
   logic              flow_enable_ff;
   logic [WAIT_W-1:0] wait_limit_ff;

   // request register
   logic              req_valid_ff;
   logic [OP_W-1:0]   op_ff;
   logic [BYTE_W-1:0] write_byte_ff;
   logic              rx_valid_ff;
   logic [BYTE_W-1:0] rx_byte_ff;
   logic              tx_ready_ff;

   // console state
   logic [TX_IW-1:0]  tx_fill_ff, tx_fill_in;
   logic [TX_IW-1:0]  tx_sent_ff, tx_sent_in;
   logic [RX_IW-1:0]  rx_fill_ff, rx_fill_in;
   logic [RX_IW-1:0]  rx_taken_ff, rx_taken_in;
   logic              cr_done_ff, cr_done_in;
   logic              xoff_ff, xoff_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [ERR_W-1:0]  err_ff, err_in;

   // response register
   logic              rsp_valid_ff;
   logic [PAY_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              step;
   logic              tx_wr_en, rx_wr_en;
   logic [BYTE_W-1:0] tx_head, rx_head;
   logic [TX_IW-1:0]  tx_rd_idx;
   logic [RX_IW-1:0]  rx_rd_idx;
   logic              txv, rdv;
   logic [BYTE_W-1:0] txb, rdb;
   logic [WAIT_W:0]   wait_inc;
   logic [WAIT_W-1:0] limit;
   logic [RX_IW-1:0]  rx_wr_idx;

   assign step       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         crlf_enable_ff <= 1'b1;
         flow_enable_ff <= 1'b1;
         wait_limit_ff  <= WAIT_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_CRLF_ENABLE: crlf_enable_ff <= csr_wdata[0];
            REG_FLOW_ENABLE: flow_enable_ff <= csr_wdata[0];
            REG_WAIT_LIMIT:  wait_limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff         <= req_tuser;
         write_byte_ff <= req_tdata[7:0];
         rx_valid_ff   <= req_tdata[8];
         rx_byte_ff    <= req_tdata[16:9];
         tx_ready_ff   <= req_tdata[17];
      end
   end

   always_comb begin
      tx_fill_in  = tx_fill_ff;
      tx_sent_in  = tx_sent_ff;
      rx_fill_in  = rx_fill_ff;
      rx_taken_in = rx_taken_ff;
      cr_done_in  = cr_done_ff;
      xoff_in     = xoff_ff;
      wait_in     = wait_ff;
      err_in      = err_ff;
      tx_wr_en    = 1'b0;
      rx_wr_en    = 1'b0;
      rx_wr_idx   = rx_fill_ff;
      txv         = 1'b0;
      txb         = '0;
      rdv         = 1'b0;
      rdb         = '0;
      wait_inc    = {1'b0, wait_ff} + 1'b1;
      limit       = (wait_limit_ff == '0) ? WAIT_W'(1) : wait_limit_ff;

      unique case (op_ff)
         OP_WRITE: begin
            if (tx_fill_ff < TX_FULL) begin
               tx_wr_en   = step;
               tx_fill_in = tx_fill_ff + 1'b1;
            end else begin
               err_in = ERR_TX_FULL;
            end
         end
         OP_READ: begin
            if (rx_taken_ff < rx_fill_ff) begin
               rdv         = 1'b1;
               rdb         = rx_head;
               rx_taken_in = rx_taken_ff + 1'b1;
            end
         end
         OP_TICK: begin
            // take the received byte first so XON/XOFF acts on this tick
            if (rx_valid_ff) begin
               if (flow_enable_ff && (rx_byte_ff == CH_XOFF)) begin
                  xoff_in = 1'b1;
               end else if (flow_enable_ff && (rx_byte_ff == CH_XON)) begin
                  xoff_in = 1'b0;
               end else begin
                  if (rx_fill_ff == rx_taken_ff) begin
                     rx_fill_in  = '0;
                     rx_taken_in = '0;
                  end
                  if (rx_fill_in < RX_FULL) begin
                     rx_wr_en   = step;
                     rx_wr_idx  = rx_fill_in;
                     rx_fill_in = rx_fill_in + 1'b1;
                  end else begin
                     err_in = ERR_RX_OVER;
                  end
               end
            end
            if (tx_sent_ff < tx_fill_ff) begin
               if ((flow_enable_ff && xoff_in) || !tx_ready_ff) begin
                  if (wait_inc >= {1'b0, limit}) begin
                     // timeout: drop the byte and any CR owed for it, and clear XOFF
                     err_in     = ERR_TIMEOUT;
                     tx_sent_in = tx_sent_ff + 1'b1;
                     cr_done_in = 1'b0;
                     xoff_in    = 1'b0;
                     wait_in    = '0;
                  end else begin
                     wait_in = wait_inc[WAIT_W-1:0];
                  end
               end else begin
                  wait_in = '0;
                  txv     = 1'b1;
                  if (crlf_enable_ff && (tx_head == CH_LF) && !cr_done_ff) begin
                     txb        = CH_CR;
                     cr_done_in = 1'b1;
                  end else begin
                     txb        = tx_head;
                     tx_sent_in = tx_sent_ff + 1'b1;
                     cr_done_in = 1'b0;
                  end
               end
            end else begin
               tx_fill_in = '0;
               tx_sent_in = '0;
               cr_done_in = 1'b0;
               wait_in    = '0;
            end
         end
         OP_NONE: ;
         default: ;
      endcase

      rsp_data_in = {flow_enable_ff && xoff_in, err_in, tx_fill_in - tx_sent_in,
                     rx_fill_in - rx_taken_in, rdb, rdv, txb, txv};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_fill_ff  <= '0;
         tx_sent_ff  <= '0;
         rx_fill_ff  <= '0;
         rx_taken_ff <= '0;
         cr_done_ff  <= 1'b0;
         xoff_ff     <= 1'b0;
         wait_ff     <= '0;
         err_ff      <= ERR_NONE;
      end else if (step) begin
         tx_fill_ff  <= tx_fill_in;
         tx_sent_ff  <= tx_sent_in;
         rx_fill_ff  <= rx_fill_in;
         rx_taken_ff <= rx_taken_in;
         cr_done_ff  <= cr_done_in;
         xoff_ff     <= xoff_in;
         wait_ff     <= wait_in;
         err_ff      <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   // read ports follow the indices the state will hold next cycle
   assign tx_rd_idx = step ? tx_sent_in : tx_sent_ff;
   assign rx_rd_idx = step ? rx_taken_in : rx_taken_ff;

   bucx_store #(
      .DEPTH (TX_DEPTH),
      .AW    (TX_AW)
   ) u_tx_store (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_fill_ff[TX_AW-1:0]),
      .wr_data (write_byte_ff),
      .rd_addr (tx_rd_idx[TX_AW-1:0]),
      .rd_data (tx_head)
   );

   bucx_store #(
      .DEPTH (RX_DEPTH),
      .AW    (RX_AW)
   ) u_rx_store (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_idx[RX_AW-1:0]),
      .wr_data (rx_byte_ff),
      .rd_addr (rx_rd_idx[RX_AW-1:0]),
      .rd_data (rx_head)
   );

endmodule
